@@ design/sclq_pkg.sv @@
`default_nettype none

package sclq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 16;
    localparam int PID_W        = 16;
    localparam int OCC_W        = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic             op;
        logic [PID_W-1:0] pid;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [PID_W-1:0] removed_pid;
        logic [OCC_W-1:0] occupied;
    } rsp_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_SCAN,
        CMD_LINK1,
        CMD_LINK2,
        CMD_POP,
        CMD_DONE_OK,
        CMD_DONE_FAIL
    } cmd_t;

    typedef struct packed {
        logic req_remove;
        logic empty;
        logic full;
        logic scan_done;
        logic rsp_free;
    } status_t;

endpackage

`default_nettype wire

@@ design/sorted_cursor_list_queue.sv @@
// Insert: the result follows the cursor walk through the link RAMs and the free-cell search,
//   one step per cycle, then the relink in LINK1 and LINK2.
// Remove: the head is popped in POP, then the result loads. A full-insert or empty-remove fails with no scan or pop.
// One transaction in flight: the next accept comes in the cycle after the result loads;
//   the response register lets the result wait on rsp_stall, holding off the next request.
// Reset (rst_n, async low) clears control, head/tail/count and used bits; link RAMs are not cleared.
`default_nettype none

module sorted_cursor_list_queue #(
    parameter int CAPACITY = sclq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = sclq_pkg::ID_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire sclq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output sclq_pkg::rsp_t      rsp
);
    import sclq_pkg::*;

    cmd_t    cmd;
    status_t status;

    sclq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sclq_dp #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ design/sclq_ram.sv @@
`default_nettype none

module sclq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/sclq_ctrl.sv @@
`default_nettype none

module sclq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire sclq_pkg::status_t status,
    output sclq_pkg::cmd_t         cmd
);
    import sclq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LINK1,
        ST_LINK2,
        ST_POP,
        ST_DONE_OK,
        ST_DONE_FAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd = CMD_START;
                    if (status.req_remove == OP_REMOVE)
                    begin
                        state_next = status.empty ? ST_DONE_FAIL : ST_POP;
                    end
                    else
                    begin
                        state_next = status.full ? ST_DONE_FAIL : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd = CMD_SCAN;
                if (status.scan_done)
                begin
                    state_next = ST_LINK1;
                end
            end
            ST_LINK1:
            begin
                cmd        = CMD_LINK1;
                state_next = ST_LINK2;
            end
            ST_LINK2:
            begin
                cmd        = CMD_LINK2;
                state_next = ST_DONE_OK;
            end
            ST_POP:
            begin
                cmd        = CMD_POP;
                state_next = ST_DONE_OK;
            end
            ST_DONE_OK:
            begin
                if (status.rsp_free)
                begin
                    cmd        = CMD_DONE_OK;
                    state_next = ST_IDLE;
                end
            end
            ST_DONE_FAIL:
            begin
                if (status.rsp_free)
                begin
                    cmd        = CMD_DONE_FAIL;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ design/sclq_dp.sv @@
`default_nettype none

module sclq_dp #(
    parameter int CAPACITY = sclq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = sclq_pkg::ID_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sclq_pkg::cmd_t    cmd,
    output sclq_pkg::status_t      status,
    input  wire sclq_pkg::req_t    req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output sclq_pkg::rsp_t         rsp
);
    import sclq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] END_MARK = CW'(CAPACITY);

    // control state
    logic [CAPACITY-1:0] used_reg, used_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                walk_done_reg, walk_done_next;
    logic                found_reg, found_next;
    logic                free_found_reg, free_found_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // payload
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       steps_reg, steps_next;
    logic [CW-1:0]       found_prev_reg, found_prev_next;
    logic [IW-1:0]       fidx_reg, fidx_next;
    logic [IW-1:0]       free_reg, free_next;
    logic [ID_BITS-1:0]  removed_reg, removed_next;
    rsp_t                rsp_reg, rsp_next;

    // link memories
    logic [IW-1:0]       rd_addr;
    logic [ID_BITS-1:0]  ids_rdata;
    logic [CW-1:0]       nxt_rdata;
    logic [CW-1:0]       prv_rdata;
    logic                ids_we, nxt_we, prv_we;
    logic [IW-1:0]       nxt_waddr, prv_waddr;
    logic [CW-1:0]       nxt_wdata, prv_wdata;

    logic                count_zero;
    logic                next_stray;
    logic [IW-1:0]       next_cell;

    assign count_zero = (count_reg == '0);
    assign next_stray = (nxt_rdata >= END_MARK);
    assign next_cell  = nxt_rdata[IW-1:0];

    always_comb
    begin
        used_next       = used_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        walk_done_next  = walk_done_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        id_next         = id_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        found_prev_next = found_prev_reg;
        fidx_next       = fidx_reg;
        free_next       = free_reg;
        removed_next    = removed_reg;
        rsp_next        = rsp_reg;
        rd_addr         = cur_reg;
        ids_we          = 1'b0;
        nxt_we          = 1'b0;
        prv_we          = 1'b0;
        nxt_waddr       = free_reg;
        prv_waddr       = free_reg;
        nxt_wdata       = END_MARK;
        prv_wdata       = END_MARK;

        unique case (cmd) inside
            CMD_NONE:
            begin
            end
            CMD_START:
            begin
                id_next         = ID_BITS'(req.pid);
                cur_next        = head_reg;
                rd_addr         = head_reg;
                steps_next      = '0;
                walk_done_next  = 1'b0;
                found_next      = 1'b0;
                fidx_next       = '0;
                free_found_next = 1'b0;
                removed_next    = '0;
            end
            CMD_SCAN:
            begin
                // lowest free cell, one used bit per cycle
                if (!free_found_reg)
                begin
                    if (!used_reg[fidx_reg])
                    begin
                        free_next       = fidx_reg;
                        free_found_next = 1'b1;
                    end
                    else
                    begin
                        fidx_next = fidx_reg + 1'b1;
                    end
                end
                // walk: read data belongs to cur_reg, next read issued from next link
                if (!walk_done_reg)
                begin
                    if (count_zero)
                    begin
                        walk_done_next = 1'b1;
                    end
                    else if (ids_rdata > id_reg)
                    begin
                        walk_done_next  = 1'b1;
                        found_next      = 1'b1;
                        found_prev_next = prv_rdata;
                    end
                    else if ((CW'(steps_reg + 1'b1) == count_reg) || next_stray)
                    begin
                        walk_done_next = 1'b1;
                    end
                    else
                    begin
                        steps_next = CW'(steps_reg + 1'b1);
                        cur_next   = next_cell;
                        rd_addr    = next_cell;
                    end
                end
            end
            CMD_LINK1:
            begin
                ids_we              = 1'b1;
                nxt_we              = 1'b1;
                nxt_waddr           = free_reg;
                nxt_wdata           = found_reg ? CW'(cur_reg) : END_MARK;
                prv_we              = 1'b1;
                prv_waddr           = free_reg;
                if (count_zero)
                begin
                    prv_wdata = END_MARK;
                    head_next = free_reg;
                    tail_next = free_reg;
                end
                else
                begin
                    prv_wdata = found_reg ? found_prev_reg : CW'(tail_reg);
                end
                used_next[free_reg] = 1'b1;
            end
            CMD_LINK2:
            begin
                count_next = CW'(count_reg + 1'b1);
                if (!count_zero)
                begin
                    if (found_reg)
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = cur_reg;
                        prv_wdata = CW'(free_reg);
                        if (found_prev_reg >= END_MARK)
                        begin
                            head_next = free_reg;
                        end
                        else
                        begin
                            nxt_we    = 1'b1;
                            nxt_waddr = found_prev_reg[IW-1:0];
                            nxt_wdata = CW'(free_reg);
                        end
                    end
                    else
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = tail_reg;
                        nxt_wdata = CW'(free_reg);
                        tail_next = free_reg;
                    end
                end
            end
            CMD_POP:
            begin
                removed_next        = used_reg[head_reg] ? ids_rdata : '0;
                used_next[head_reg] = 1'b0;
                count_next          = CW'(count_reg - 1'b1);
                if (count_reg == CW'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    head_next = next_stray ? '0 : next_cell;
                    prv_we    = 1'b1;
                    prv_waddr = next_stray ? '0 : next_cell;
                    prv_wdata = END_MARK;
                end
            end
            CMD_DONE_OK, CMD_DONE_FAIL:
            begin
                rsp_next.ok          = (cmd == CMD_DONE_OK);
                rsp_next.removed_pid = PID_W'(removed_reg);
                rsp_next.occupied    = OCC_W'(count_reg);
                rsp_valid_next       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            walk_done_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            walk_done_reg  <= walk_done_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        found_prev_reg <= found_prev_next;
        fidx_reg       <= fidx_next;
        free_reg       <= free_next;
        removed_reg    <= removed_next;
        rsp_reg        <= rsp_next;
    end

    sclq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CAPACITY)
    ) u_ids_ram (
        .clk   (clk),
        .we    (ids_we),
        .waddr (free_reg),
        .wdata (id_reg),
        .raddr (rd_addr),
        .rdata (ids_rdata)
    );

    sclq_ram #(
        .WIDTH (CW),
        .DEPTH (CAPACITY)
    ) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    sclq_ram #(
        .WIDTH (CW),
        .DEPTH (CAPACITY)
    ) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    assign status.req_remove = req.op;
    assign status.empty      = count_zero;
    assign status.full       = (count_reg == END_MARK);
    assign status.scan_done  = walk_done_reg && free_found_reg;
    assign status.rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    import sclq_pkg::*;

    localparam int          CLK_HALF   = 10;
    localparam int          RESET_CYC  = 11;
    localparam int          STALL_LIM  = 3000;
    localparam int          DRAIN_CYC  = 40;
    localparam int          RAND_ITEMS = 410;
    localparam logic [15:0] ID_MASK    = 16'((1 << ID_BITS_DEF) - 1);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req_data  = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp_data;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    logic [15:0] held_ids[$];      // ids in list order, smallest first

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int failures      = 0;
    int idle_cycles   = 0;
    bit req_fired     = 1'b0;
    int gen_occ       = 0;
    bit draining      = 1'b0;

    sorted_cursor_list_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_data)
    );

    always #CLK_HALF clk = ~clk;

    // Sorted insert places a new id after all equal ones; remove pops the front.
    function automatic rsp_t predict_queue_op(input req_t r);
        rsp_t        res;
        logic [15:0] id;
        int          pos;
        res = '0;
        if (r.op == OP_INSERT) begin
            if (held_ids.size() < CAPACITY_DEF) begin
                id  = r.pid & ID_MASK;
                pos = held_ids.size();
                for (int i = 0; i < held_ids.size(); i++)
                begin
                    if (held_ids[i] > id)
                    begin
                        pos = i;
                        break;
                    end
                end
                held_ids.insert(pos, id);
                res.ok = 1'b1;
            end
        end else begin
            if (held_ids.size() != 0)
            begin
                res.removed_pid = held_ids.pop_front();
                res.ok          = 1'b1;
            end
        end
        res.occupied = OCC_W'(held_ids.size());
        return res;
    endfunction

    function automatic logic [15:0] pick_pid();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
            return 16'($urandom_range(7));
        else if (sel < 30)
            return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        else
            return 16'($urandom());
    endfunction

    task automatic add_item(input logic op, input logic [15:0] pid);
        req_t item;
        item.op  = op;
        item.pid = pid;
        pending_reqs.push_back(item);
        if (op == OP_INSERT)
            gen_occ = (gen_occ < CAPACITY_DEF) ? gen_occ + 1 : gen_occ;
        else
            gen_occ = (gen_occ > 0) ? gen_occ - 1 : 0;
    endtask

    // Alternate fill and drain runs so full and empty are both hit often.
    task automatic queue_random_items(input int n);
        logic op;
        for (int k = 0; k < n; k++)
        begin
            if (!draining && gen_occ == CAPACITY_DEF && $urandom_range(99) < 30)
                draining = 1'b1;
            else if (draining && gen_occ == 0 && $urandom_range(99) < 30)
                draining = 1'b0;
            if ($urandom_range(99) < 75)
                op = draining ? OP_REMOVE : OP_INSERT;
            else
                op = draining ? OP_INSERT : OP_REMOVE;
            add_item(op, pick_pid());
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_fired)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_reqs.pop_front();
                end else begin
                    req_valid <= 1'b0;
                end
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        bit   rsp_fired;
        if (rst_n)
        begin
            req_fired = req_valid && !req_stall;
            rsp_fired = rsp_valid && !rsp_stall;
            if (req_fired)
                expected_rsps.push_back(predict_queue_op(req_data));
            if (rsp_fired)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    failures++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_data.ok !== want.ok)
                    begin
                        $error("ok: expected %0d actual %0d", want.ok, rsp_data.ok);
                        failures++;
                    end
                    if (rsp_data.removed_pid !== want.removed_pid)
                    begin
                        $error("removed_pid: expected %0d actual %0d",
                               want.removed_pid, rsp_data.removed_pid);
                        failures++;
                    end
                    if (rsp_data.occupied !== want.occupied)
                    begin
                        $error("occupied: expected %0d actual %0d",
                               want.occupied, rsp_data.occupied);
                        failures++;
                    end
                end
            end
            if (req_fired || rsp_fired)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIM)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // remove on empty, fill with extremes and duplicates, insert on full
        add_item(OP_REMOVE, 16'h1234);
        add_item(OP_INSERT, 16'hFFFF);
        add_item(OP_INSERT, 16'h0000);
        add_item(OP_INSERT, 16'h8000);
        add_item(OP_INSERT, 16'h8000);
        add_item(OP_INSERT, 16'h0000);
        add_item(OP_INSERT, 16'hFFFF);
        add_item(OP_INSERT, 16'h0001);
        add_item(OP_INSERT, 16'h7FFF);
        add_item(OP_INSERT, 16'hFFFE);
        add_item(OP_INSERT, 16'h5555);
        add_item(OP_INSERT, 16'hAAAA);
        add_item(OP_INSERT, 16'h1234);
        add_item(OP_INSERT, 16'h8000);
        add_item(OP_INSERT, 16'h0003);
        add_item(OP_INSERT, 16'h0002);
        add_item(OP_INSERT, 16'h0001);
        add_item(OP_INSERT, 16'h4242);
        repeat (5) add_item(OP_REMOVE, 16'hFFFF);

        // no idling, sender idle, receiver stalling, both
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_random_items(RAND_ITEMS);
        wait_drained();
        send_idle_pct = 84;
        stall_pct     = 0;
        queue_random_items(RAND_ITEMS);
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 84;
        queue_random_items(RAND_ITEMS);
        wait_drained();
        send_idle_pct = 17;
        stall_pct     = 17;
        queue_random_items(RAND_ITEMS);
        wait_drained();

        repeat (DRAIN_CYC) @(posedge clk);
        if (failures == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
design/sclq_pkg.sv
design/sclq_ram.sv
design/sclq_ctrl.sv
design/sclq_dp.sv
design/sorted_cursor_list_queue.sv
tb/tb_top.sv
